[design/lsp_pkg.sv]
// shared constants, types and helper functions of the line sensor position block
`default_nettype none

package lsp_pkg;

    localparam int NUM_SENSORS = 8;
    localparam int ADC_BITS    = 12;
    localparam int OP_W        = 2;
    localparam int POS_W       = 11;
    localparam int CNT_W       = 4;

    localparam int IN_DATA_W  = ((NUM_SENSORS * ADC_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((POS_W + CNT_W + 7) / 8) * 8;

    // signed sum of doubled weights, bounded by NUM_SENSORS^2 / 4
    localparam int SUM_W      = $clog2(NUM_SENSORS * NUM_SENSORS) + 1;
    localparam int FRAC_SHIFT = 7;
    localparam int MAG_W      = SUM_W - 1 + FRAC_SHIFT;

    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = (MAG_W + DIV_BITS - 1) / DIV_BITS;
    localparam int DIV_W     = DIV_STEPS * DIV_BITS;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);
    localparam int REM_W     = CNT_W + 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

    typedef logic [ADC_BITS-1:0] level_t;

    typedef enum logic [OP_W-1:0] {
        OP_MEASURE   = 2'd0,
        OP_CAL_WHITE = 2'd1,
        OP_CAL_BLACK = 2'd2,
        OP_UNUSED    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_WRITE
    } back_state_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum2w;
        logic [CNT_W-1:0]        count;
    } meas_t;

    typedef struct packed {
        logic pop;
        logic step;
        logic write;
    } back_ctl_t;

    function automatic level_t thr_of(level_t w, level_t b);
        logic [ADC_BITS:0] s;
        s = {1'b0, w} + {1'b0, b};
        return s[ADC_BITS:1];
    endfunction

    function automatic logic signed [SUM_W-1:0] weight2(int i);
        return SUM_W'(2 * i - (NUM_SENSORS - 1));
    endfunction

    localparam level_t WHITE_RESET = level_t'(3850);
    localparam level_t BLACK_RESET = level_t'(4000);
    localparam level_t THR_RESET   = thr_of(WHITE_RESET, BLACK_RESET);

endpackage

`default_nettype wire

[design/line_sensor_position_with_calibration_top.sv]
// top level of the line sensor position block with white/black calibration
// a measure item is classified and queued as it is accepted; the back end then pops it,
// runs the DIV_STEPS steps of the 4-bit-per-cycle divider and writes the output register
// once it is free; calibrate items are taken one per cycle while the queue is not full
// the 2-entry queue lets the front take items while the back divides
// reset: white 3850, black 4000, thresholds 3925 on every sensor; queue empty
`default_nettype none

module line_sensor_position_with_calibration_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [lsp_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // reading_0 .. reading_7
    input  wire logic [lsp_pkg::OP_W-1:0]        s_axis_tuser,  // op
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [lsp_pkg::OUT_DATA_W-1:0]       m_axis_tdata   // position, active_count
);

    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_empty;
    lsp_pkg::meas_t q_in;
    lsp_pkg::meas_t q_out;

    lsp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_in)
    );

    lsp_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    lsp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_data        (q_out),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

[design/lsp_front.sv]
// front end: takes items, keeps calibration levels, classifies sensors for measure items
`default_nettype none

module lsp_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [lsp_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  wire logic [lsp_pkg::OP_W-1:0]        s_axis_tuser,
    input  wire logic                            q_full,
    output logic                                 q_push,
    output lsp_pkg::meas_t                       q_data
);

    lsp_pkg::level_t white_reg [lsp_pkg::NUM_SENSORS];
    lsp_pkg::level_t black_reg [lsp_pkg::NUM_SENSORS];
    lsp_pkg::level_t thr_reg   [lsp_pkg::NUM_SENSORS];
    lsp_pkg::level_t reading   [lsp_pkg::NUM_SENSORS];

    lsp_pkg::op_t op;
    logic         accept;
    logic signed [lsp_pkg::SUM_W-1:0] sum;
    logic [lsp_pkg::CNT_W-1:0]        cnt;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && !q_full;
    assign op            = lsp_pkg::op_t'(s_axis_tuser);

    always_comb
    begin
        for (int i = 0; i < lsp_pkg::NUM_SENSORS; i++)
        begin
            reading[i] = s_axis_tdata[i*lsp_pkg::ADC_BITS +: lsp_pkg::ADC_BITS];
        end
    end

    // active sensors: reading strictly below threshold
    always_comb
    begin
        sum = '0;
        cnt = '0;
        for (int i = 0; i < lsp_pkg::NUM_SENSORS; i++)
        begin
            if (reading[i] < thr_reg[i])
            begin
                sum = sum + lsp_pkg::weight2(i);
                cnt = cnt + lsp_pkg::CNT_W'(1);
            end
        end
    end

    assign q_push       = accept && (op == lsp_pkg::OP_MEASURE);
    assign q_data.sum2w = sum;
    assign q_data.count = cnt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < lsp_pkg::NUM_SENSORS; i++)
            begin
                white_reg[i] <= lsp_pkg::WHITE_RESET;
                black_reg[i] <= lsp_pkg::BLACK_RESET;
                thr_reg[i]   <= lsp_pkg::THR_RESET;
            end
        end
        else if (accept)
        begin
            for (int i = 0; i < lsp_pkg::NUM_SENSORS; i++)
            begin
                if (op == lsp_pkg::OP_CAL_WHITE)
                begin
                    white_reg[i] <= reading[i];
                    thr_reg[i]   <= lsp_pkg::thr_of(reading[i], black_reg[i]);
                end
                else if (op == lsp_pkg::OP_CAL_BLACK)
                begin
                    black_reg[i] <= reading[i];
                    thr_reg[i]   <= lsp_pkg::thr_of(white_reg[i], reading[i]);
                end
            end
        end
    end

endmodule

`default_nettype wire

[design/lsp_fifo.sv]
// short queue of classified measure items between front and back
`default_nettype none

module lsp_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire lsp_pkg::meas_t push_data,
    output logic                full,
    input  wire logic           pop,
    output lsp_pkg::meas_t      pop_data,
    output logic                empty
);

    lsp_pkg::meas_t mem_reg [lsp_pkg::QUEUE_DEPTH];

    logic [lsp_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [lsp_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [lsp_pkg::QFILL_W-1:0] fill_reg, fill_next;

    assign full     = (fill_reg == lsp_pkg::QFILL_W'(lsp_pkg::QUEUE_DEPTH));
    assign empty    = (fill_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + lsp_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + lsp_pkg::QPTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + lsp_pkg::QFILL_W'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - lsp_pkg::QFILL_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue pop while empty");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= lsp_pkg::QFILL_W'(lsp_pkg::QUEUE_DEPTH))
        else $error("queue fill count out of range");

endmodule

`default_nettype wire

[design/lsp_back.sv]
// back end: divides the scaled weight sum by the active count and holds the result
`default_nettype none

module lsp_back (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            q_empty,
    input  wire lsp_pkg::meas_t                  q_data,
    output logic                                 q_pop,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [lsp_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);

    lsp_pkg::back_state_t state_reg, state_next;
    lsp_pkg::back_ctl_t   ctl;

    logic [lsp_pkg::DIV_W-1:0]  dvd_reg, dvd_next;
    logic [lsp_pkg::DIV_W-1:0]  quo_reg, quo_next;
    logic [lsp_pkg::REM_W-1:0]  rem_reg, rem_next;
    logic [lsp_pkg::CNT_W-1:0]  cnt_reg;
    logic                       neg_reg;
    logic [lsp_pkg::STEP_W-1:0] step_reg;

    logic                             out_valid_reg;
    logic signed [lsp_pkg::POS_W-1:0] out_pos_reg, pos_next;
    logic [lsp_pkg::CNT_W-1:0]        out_cnt_reg;

    logic                           out_free;
    logic                           last_step;
    logic [lsp_pkg::SUM_W-1:0]      sum_abs;
    logic [lsp_pkg::POS_W-1:0]      quo_low;

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign last_step = (step_reg == lsp_pkg::STEP_W'(lsp_pkg::DIV_STEPS - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lsp_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = lsp_pkg::B_DIV;
                end
            end
            lsp_pkg::B_DIV:
            begin
                if (last_step)
                begin
                    state_next = lsp_pkg::B_WRITE;
                end
            end
            lsp_pkg::B_WRITE:
            begin
                if (out_free)
                begin
                    state_next = lsp_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = lsp_pkg::B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl = '0;
        unique case (state_reg)
            lsp_pkg::B_IDLE:  ctl.pop   = !q_empty;
            lsp_pkg::B_DIV:   ctl.step  = 1'b1;
            lsp_pkg::B_WRITE: ctl.write = out_free;
            default:          ctl       = '0;
        endcase
    end

    assign q_pop   = ctl.pop;
    assign sum_abs = q_data.sum2w[lsp_pkg::SUM_W-1] ? -q_data.sum2w : q_data.sum2w;

    // restoring division, DIV_BITS quotient bits per cycle, msb first
    always_comb
    begin
        dvd_next = dvd_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        for (int k = 0; k < lsp_pkg::DIV_BITS; k++)
        begin
            rem_next = {rem_next[lsp_pkg::REM_W-2:0], dvd_next[lsp_pkg::DIV_W-1]};
            dvd_next = {dvd_next[lsp_pkg::DIV_W-2:0], 1'b0};
            if (rem_next >= {1'b0, cnt_reg})
            begin
                rem_next = rem_next - {1'b0, cnt_reg};
                quo_next = {quo_next[lsp_pkg::DIV_W-2:0], 1'b1};
            end
            else
            begin
                quo_next = {quo_next[lsp_pkg::DIV_W-2:0], 1'b0};
            end
        end
    end

    // truncation toward zero: divide the magnitude, then restore the sign
    assign quo_low = quo_reg[lsp_pkg::POS_W-1:0];
    always_comb
    begin
        if (cnt_reg == '0)
        begin
            pos_next = '0;
        end
        else if (neg_reg)
        begin
            pos_next = -$signed(quo_low);
        end
        else
        begin
            pos_next = $signed(quo_low);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.pop)
        begin
            dvd_reg <= lsp_pkg::DIV_W'({sum_abs, {lsp_pkg::FRAC_SHIFT{1'b0}}});
            quo_reg <= '0;
            rem_reg <= '0;
            cnt_reg <= q_data.count;
            neg_reg <= q_data.sum2w[lsp_pkg::SUM_W-1];
        end
        else if (ctl.step)
        begin
            dvd_reg <= dvd_next;
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
        if (ctl.write)
        begin
            out_pos_reg <= pos_next;
            out_cnt_reg <= cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lsp_pkg::B_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ctl.pop)
            begin
                step_reg <= '0;
            end
            else if (ctl.step)
            begin
                step_reg <= step_reg + lsp_pkg::STEP_W'(1);
            end
            if (ctl.write)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = lsp_pkg::OUT_DATA_W'({out_cnt_reg, out_pos_reg});

    a_zero_count_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_cnt_reg == '0) |-> (out_pos_reg == '0))
        else $error("no active sensor but nonzero position");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lsp_pkg::B_DIV) |-> (step_reg < lsp_pkg::STEP_W'(lsp_pkg::DIV_STEPS)))
        else $error("divider step counter overran");

    a_write_shows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.write |=> out_valid_reg)
        else $error("finished item not presented");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_cnt_reg <= lsp_pkg::CNT_W'(lsp_pkg::NUM_SENSORS)))
        else $error("active count above sensor count");

endmodule

`default_nettype wire

[tb/line_sensor_position_with_calibration_top_test.sv]
// self-checking testbench of the line sensor position block with white/black calibration
module line_sensor_position_with_calibration_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lsp_pkg::*;

    localparam int QUIET_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 16;
    localparam int RANDOM_SCANS = 950;
    localparam level_t ADC_MAX  = level_t'((1 << ADC_BITS) - 1);

    typedef struct packed {
        op_t                   op;
        logic [IN_DATA_W-1:0]  data;
    } scan_t;

    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic [CNT_W-1:0]        count;
    } line_fix_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [OP_W-1:0]       s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    scan_t     pending_scans[$];
    line_fix_t expected_fixes[$];
    scan_t     held_scan;

    // predictor state
    level_t white_lv[NUM_SENSORS];
    level_t black_lv[NUM_SENSORS];
    level_t thr_lv[NUM_SENSORS];

    // generator's own view of the thresholds, used only to aim readings
    level_t gen_white[NUM_SENSORS];
    level_t gen_black[NUM_SENSORS];
    level_t gen_thr[NUM_SENSORS];

    int  send_gap = 0;
    int  stall_left = 0;
    int  quiet_cycles = 0;
    int  scans_sent = 0;
    int  fixes_seen = 0;
    int  empty_fixes = 0;
    int  cal_count = 0;
    int  mismatch_count = 0;
    logic hold_off = 1'b0;

    line_sensor_position_with_calibration_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // reading_0 .. reading_7
        .s_axis_tuser  (s_axis_tuser),   // op
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // position, active_count
    );

    always #4 clk = ~clk;

    function automatic int pick_gap(input logic no_idle);
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 40);
    endfunction

    function automatic logic burst_phase(input int n);
        return ((n / 100) % 5) == 2;
    endfunction

    function automatic logic [IN_DATA_W-1:0] all_readings(input level_t v);
        logic [IN_DATA_W-1:0] d;
        d = '0;
        for (int i = 0; i < NUM_SENSORS; i++)
            d[i*ADC_BITS +: ADC_BITS] = v;
        return d;
    endfunction

    // readings clustered around the current thresholds, with rail and random values mixed in
    function automatic level_t aim_reading(input level_t t);
        int r;
        int v;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return ADC_MAX;
        else if (r < 6)
        begin
            v = int'(t) + $urandom_range(0, 6) - 3;
            if (v < 0)
                v = 0;
            if (v > int'(ADC_MAX))
                v = int'(ADC_MAX);
            return level_t'(v);
        end
        else
            return level_t'($urandom);
    endfunction

    task automatic queue_scan(input op_t op, input logic [IN_DATA_W-1:0] data);
        scan_t s;
        s.op = op;
        s.data = data;
        if (op == OP_CAL_WHITE || op == OP_CAL_BLACK)
        begin
            for (int i = 0; i < NUM_SENSORS; i++)
            begin
                if (op == OP_CAL_WHITE)
                    gen_white[i] = data[i*ADC_BITS +: ADC_BITS];
                else
                    gen_black[i] = data[i*ADC_BITS +: ADC_BITS];
                gen_thr[i] = level_t'(({1'b0, gen_white[i]} + {1'b0, gen_black[i]}) >> 1);
            end
        end
        pending_scans.push_back(s);
    endtask

    task automatic predict_scan(input scan_t s);
        int        sum2w;
        int        cnt;
        level_t    r;
        line_fix_t fix;
        sum2w = 0;
        cnt = 0;
        case (s.op)
            OP_CAL_WHITE, OP_CAL_BLACK:
            begin
                for (int i = 0; i < NUM_SENSORS; i++)
                begin
                    r = s.data[i*ADC_BITS +: ADC_BITS];
                    if (s.op == OP_CAL_WHITE)
                        white_lv[i] = r;
                    else
                        black_lv[i] = r;
                    thr_lv[i] = level_t'(({1'b0, white_lv[i]} + {1'b0, black_lv[i]}) >> 1);
                end
                cal_count++;
            end
            OP_MEASURE:
            begin
                for (int i = 0; i < NUM_SENSORS; i++)
                begin
                    r = s.data[i*ADC_BITS +: ADC_BITS];
                    if (r < thr_lv[i])
                    begin
                        sum2w += 2 * i - (NUM_SENSORS - 1);
                        cnt++;
                    end
                end
                // integer division truncates toward zero
                fix.position = (cnt > 0) ? POS_W'((sum2w * 128) / cnt) : '0;
                fix.count = CNT_W'(cnt);
                expected_fixes.push_back(fix);
            end
            default:
                ;
        endcase
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= '0;
            send_gap <= 0;
            for (int i = 0; i < NUM_SENSORS; i++)
            begin
                white_lv[i] = WHITE_RESET;
                black_lv[i] = BLACK_RESET;
                thr_lv[i] = THR_RESET;
            end
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_scan(held_scan);
                scans_sent <= scans_sent + 1;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_scans.size() > 0)
                begin
                    held_scan = pending_scans.pop_front();
                    s_axis_tdata <= held_scan.data;
                    s_axis_tuser <= held_scan.op;
                    s_axis_tvalid <= 1'b1;
                    // keep offering while the receiver is held off
                    send_gap <= hold_off ? 0 : pick_gap(burst_phase(scans_sent));
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        line_fix_t fix;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                fixes_seen <= fixes_seen + 1;
                if (expected_fixes.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("unexpected item on output: data %h", m_axis_tdata);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    fix = expected_fixes.pop_front();
                    if (fix.count == 0)
                        empty_fixes <= empty_fixes + 1;
                    if (m_axis_tdata[POS_W-1:0] !== fix.position
                        || m_axis_tdata[POS_W +: CNT_W] !== fix.count)
                    begin
                        if (mismatch_count < 10)
                            $display("mismatch: expected position %0d count %0d, got position %0d count %0d",
                                     fix.position, fix.count,
                                     $signed(m_axis_tdata[POS_W-1:0]),
                                     m_axis_tdata[POS_W +: CNT_W]);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            if (hold_off)
                m_axis_tready <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 5) == 0)
                    stall_left <= pick_gap(burst_phase(fixes_seen + 50));
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // long receiver hold-off so the block backs up and stalls its input
    initial
    begin
        wait (scans_sent >= 400);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        logic [IN_DATA_W-1:0] d;
        int r;
        op_t op;

        for (int i = 0; i < NUM_SENSORS; i++)
        begin
            gen_white[i] = WHITE_RESET;
            gen_black[i] = BLACK_RESET;
            gen_thr[i] = THR_RESET;
        end

        // directed: reset thresholds, rails, single sensors at each end
        queue_scan(OP_MEASURE, all_readings('0));
        queue_scan(OP_MEASURE, all_readings(ADC_MAX));
        d = all_readings(ADC_MAX);
        d[0 +: ADC_BITS] = '0;
        queue_scan(OP_MEASURE, d);
        d = all_readings(ADC_MAX);
        d[(NUM_SENSORS-1)*ADC_BITS +: ADC_BITS] = '0;
        queue_scan(OP_MEASURE, d);
        // exactly at threshold is inactive, one below is active; uneven mean
        d = all_readings(THR_RESET);
        d[0 +: ADC_BITS] = level_t'(THR_RESET - 1);
        d[ADC_BITS +: ADC_BITS] = level_t'(THR_RESET - 1);
        d[(NUM_SENSORS-1)*ADC_BITS +: ADC_BITS] = level_t'(THR_RESET - 1);
        queue_scan(OP_MEASURE, d);
        // unused op leaves the state alone
        queue_scan(OP_UNUSED, all_readings('0));
        queue_scan(OP_MEASURE, all_readings(level_t'(THR_RESET - 1)));
        // thresholds at mid scale
        queue_scan(OP_CAL_WHITE, all_readings('0));
        queue_scan(OP_CAL_BLACK, all_readings(ADC_MAX));
        d = all_readings(level_t'(2047));
        d[2*ADC_BITS +: ADC_BITS] = level_t'(2046);
        queue_scan(OP_MEASURE, d);
        // thresholds at full scale
        queue_scan(OP_CAL_WHITE, all_readings(ADC_MAX));
        queue_scan(OP_MEASURE, all_readings(level_t'(ADC_MAX - 1)));
        queue_scan(OP_MEASURE, all_readings(ADC_MAX));
        // thresholds at zero: nothing can be active
        queue_scan(OP_CAL_WHITE, all_readings('0));
        queue_scan(OP_CAL_BLACK, all_readings('0));
        queue_scan(OP_MEASURE, all_readings('0));
        // per-sensor levels, white above black on some sensors
        d = '0;
        for (int i = 0; i < NUM_SENSORS; i++)
            d[i*ADC_BITS +: ADC_BITS] = level_t'(i * 500);
        queue_scan(OP_CAL_WHITE, d);
        for (int i = 0; i < NUM_SENSORS; i++)
            d[i*ADC_BITS +: ADC_BITS] = level_t'(4095 - i * 300);
        queue_scan(OP_CAL_BLACK, d);
        queue_scan(OP_MEASURE, all_readings(level_t'(2047)));
        queue_scan(OP_MEASURE, {NUM_SENSORS{12'h555}});
        queue_scan(OP_MEASURE, {NUM_SENSORS{12'haaa}});

        // random: mostly measures aimed at the thresholds, with calibrations and unused ops mixed in
        for (int n = 0; n < RANDOM_SCANS; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 6)
                op = OP_CAL_WHITE;
            else if (r < 12)
                op = OP_CAL_BLACK;
            else if (r < 15)
                op = OP_UNUSED;
            else
                op = OP_MEASURE;
            d = '0;
            for (int i = 0; i < NUM_SENSORS; i++)
            begin
                if (op == OP_MEASURE)
                    d[i*ADC_BITS +: ADC_BITS] = aim_reading(gen_thr[i]);
                else if ($urandom_range(0, 9) < 3)
                    d[i*ADC_BITS +: ADC_BITS] = level_t'($urandom);
                else if (op == OP_CAL_WHITE)
                    d[i*ADC_BITS +: ADC_BITS] = level_t'($urandom_range(0, 2000));
                else
                    d[i*ADC_BITS +: ADC_BITS] = level_t'($urandom_range(2000, 4095));
            end
            queue_scan(op, d);
        end

        while ((pending_scans.size() > 0 || s_axis_tvalid || expected_fixes.size() > 0)
               && quiet_cycles < QUIET_LIMIT)
            @(posedge clk);

        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: %0d items still expected", expected_fixes.size());
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            repeat (TAIL_CYCLES) @(posedge clk);
            if (expected_fixes.size() > 0)
            begin
                $display("%0d expected items never arrived", expected_fixes.size());
                mismatch_count = mismatch_count + expected_fixes.size();
            end
            $display("sent %0d scans (%0d calibrations), checked %0d positions, %0d with no line",
                     scans_sent, cal_count, fixes_seen, empty_fixes);
            $display("mismatches: %0d", mismatch_count);
            if (mismatch_count == 0)
                $display("RESULT: OK");
            else
                $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule
